FILE: hdl/tvc_pkg.sv
// Shared constants, codes and beat/control types for the tombstone store.
package tvc_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_ERASE   = 3'd1;
  localparam logic [2:0] KIND_READ    = 3'd2;
  localparam logic [2:0] KIND_COMPACT = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_DELETED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [6:0] THRESHOLD_RESET = 7'd10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  slot_index;
    logic [31:0] new_value;
  } tvc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        read_live;
    logic [6:0]  stored_count;
    logic [6:0]  pending_count;
    logic        compacted;
  } tvc_out_t;

  typedef struct packed {
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  kill_en;
    logic [IDX_W-1:0]      kill_idx;
    logic                  shift_en;
    logic [IDX_W-1:0]      shift_from;
  } tvc_ctrl_t;

endpackage

FILE: hdl/tvc_cell.sv
// One slot of the store: value and live mark, loads from its upper neighbor on shift.
module tvc_cell (
  input  logic                           clk,
  input  tvc_pkg::tvc_ctrl_t             ctrl,
  input  logic [tvc_pkg::IDX_W-1:0]      cell_idx,
  input  logic [tvc_pkg::DATA_WIDTH-1:0] up_value,
  input  logic                           up_live,
  output logic [tvc_pkg::DATA_WIDTH-1:0] value,
  output logic                           live
);
  import tvc_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift_en && (cell_idx >= ctrl.shift_from)) begin
      value <= up_value;
      live  <= up_live;
    end else if (ctrl.wr_en && (cell_idx == ctrl.wr_idx)) begin
      value <= ctrl.wr_data;
      live  <= 1'b1;
    end else if (ctrl.kill_en && (cell_idx == ctrl.kill_idx)) begin
      live <= 1'b0;
    end
  end

endmodule

FILE: hdl/tvc_array.sv
// Row of slot cells chained for left shifts, with a registered read tap and a hole finder.
module tvc_array (
  input  logic                           clk,
  input  tvc_pkg::tvc_ctrl_t             ctrl,
  input  logic [tvc_pkg::CNT_W-1:0]      fill,
  input  logic [tvc_pkg::IDX_W-1:0]      rd_idx,
  output logic [tvc_pkg::DATA_WIDTH-1:0] rd_value,
  output logic                           rd_live,
  output logic                           hole_any,
  output logic [tvc_pkg::IDX_W-1:0]      hole_idx
);
  import tvc_pkg::*;

  logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]   cell_live;
  logic [DATA_WIDTH-1:0] up_value   [CAPACITY];
  logic [CAPACITY-1:0]   up_live;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign up_value[i] = '0;
      assign up_live[i]  = 1'b0;
    end else begin : g_mid
      assign up_value[i] = cell_value[i+1];
      assign up_live[i]  = cell_live[i+1];
    end

    tvc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cell_idx (IDX_W'(i)),
      .up_value (up_value[i]),
      .up_live  (up_live[i]),
      .value    (cell_value[i]),
      .live     (cell_live[i])
    );
  end

  always_ff @(posedge clk) begin
    rd_value <= cell_value[rd_idx];
    rd_live  <= cell_live[rd_idx];
  end

  // lowest deleted slot below the fill level
  always_comb begin
    hole_any = 1'b0;
    hole_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!cell_live[i] && (CNT_W'(i) < fill)) begin
        hole_any = 1'b1;
        hole_idx = IDX_W'(i);
      end
    end
  end

endmodule

FILE: hdl/tombstone_vector_with_compaction_top.sv
// Top level: command decode, fill/pending counters, compaction sequencer, result register.
// Flow: an accepted item is held in the command register and executed in S_EXEC, whose
//   result is registered into out_data; compaction runs in S_COMPACT, the cell row removing
//   one deleted slot per cycle. No new item is taken until the state is back in S_IDLE and
//   the result register is free; a compacting item holds input until no hole is left.
// Reset: synchronous; clears fill level, pending count, sequencer and result valid, and
//   restores the threshold to 10. Slot contents are not cleared.
module tombstone_vector_with_compaction_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tvc_pkg::tvc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tvc_pkg::tvc_out_t out_data,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata
);
  import tvc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COMPACT} state_t;

  state_t                state, state_next;
  tvc_in_t               cmd;
  logic [CNT_W-1:0]      fill, fill_next;
  logic [6:0]            pending, pending_next;
  logic [6:0]            threshold;

  tvc_ctrl_t             ctrl;
  tvc_out_t              res;
  logic                  accept, load, idx_ok;
  logic [6:0]            pend_inc;
  logic [DATA_WIDTH-1:0] rd_value;
  logic                  rd_live, hole_any;
  logic [IDX_W-1:0]      hole_idx;

  tvc_array u_array (
    .clk      (clk),
    .ctrl     (ctrl),
    .fill     (fill),
    .rd_idx   (IDX_W'(in_data.slot_index)),
    .rd_value (rd_value),
    .rd_live  (rd_live),
    .hole_any (hole_any),
    .hole_idx (hole_idx)
  );

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = CNT_W'(cmd.slot_index) < fill;
  assign pend_inc = pending + 7'd1;

  always_comb begin
    ctrl         = '0;
    res          = '0;
    load         = 1'b0;
    state_next   = state;
    fill_next    = fill;
    pending_next = pending;
    ctrl.wr_idx     = fill[IDX_W-1:0];
    ctrl.wr_data    = DATA_WIDTH'(cmd.new_value);
    ctrl.kill_idx   = IDX_W'(cmd.slot_index);
    ctrl.shift_from = hole_idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        load       = 1'b1;
        state_next = S_IDLE;
        case (cmd.kind)
          KIND_APPEND: begin
            if (fill >= CNT_W'(CAPACITY)) begin
              res.status = ST_FULL;
            end else begin
              ctrl.wr_en = 1'b1;
              fill_next  = fill + CNT_W'(1);
            end
          end
          KIND_ERASE: begin
            if (!idx_ok) begin
              res.status = ST_RANGE;
            end else if (!rd_live) begin
              res.status = ST_DELETED;
            end else begin
              ctrl.kill_en = 1'b1;
              pending_next = pend_inc;
              if (pend_inc >= threshold) begin
                load       = 1'b0;
                state_next = S_COMPACT;
              end
            end
          end
          KIND_READ: begin
            if (!idx_ok) begin
              res.status = ST_RANGE;
            end else begin
              res.read_value = 32'(rd_value);
              res.read_live  = rd_live;
            end
          end
          KIND_COMPACT: begin
            load       = 1'b0;
            state_next = S_COMPACT;
          end
          KIND_CLEAR: begin
            fill_next    = '0;
            pending_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_COMPACT: begin
        if (hole_any) begin
          ctrl.shift_en = 1'b1;
          fill_next     = fill - CNT_W'(1);
        end else begin
          load          = 1'b1;
          pending_next  = '0;
          res.compacted = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.stored_count  = 7'(fill_next);
    res.pending_count = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pending   <= '0;
      threshold <= THRESHOLD_RESET;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      pending <= pending_next;
      if (accept) begin
        cmd <= in_data;
      end
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: dv/tvc_store_checker.sv
`timescale 1ns / 1ps
// Checker for the tombstone store: predicts each result beat and compares it field by field.
module tvc_store_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tvc_pkg::tvc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tvc_pkg::tvc_out_t out_data,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  output int                fail_count,
  output int                results_owed
);
  import tvc_pkg::*;

  logic [DATA_WIDTH-1:0] slot_value [CAPACITY];
  logic                  slot_alive [CAPACITY];
  logic [6:0]            fill_level = '0;
  logic [6:0]            tomb_count = '0;
  logic [6:0]            threshold  = THRESHOLD_RESET;
  tvc_out_t              owed_q [$];
  int                    mismatches = 0;
  int                    owed_n     = 0;

  assign fail_count   = mismatches;
  assign results_owed = owed_n;

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // drop deleted slots, keeping the order of live ones
  task automatic squeeze_store();
    int wr;
    wr = 0;
    for (int rd = 0; rd < fill_level; rd++) begin
      if (slot_alive[rd]) begin
        slot_value[wr] = slot_value[rd];
        slot_alive[wr] = 1'b1;
        wr++;
      end
    end
    fill_level = 7'(wr);
    tomb_count = '0;
  endtask

  task automatic predict_beat(input tvc_in_t cmd, output tvc_out_t res);
    res = '0;
    case (cmd.kind)
      KIND_APPEND: begin
        if (fill_level >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot_value[fill_level[5:0]] = cmd.new_value;
          slot_alive[fill_level[5:0]] = 1'b1;
          fill_level++;
        end
      end
      KIND_ERASE: begin
        if (cmd.slot_index >= fill_level) begin
          res.status = ST_RANGE;
        end else if (!slot_alive[cmd.slot_index]) begin
          res.status = ST_DELETED;
        end else begin
          slot_alive[cmd.slot_index] = 1'b0;
          tomb_count++;
          if (tomb_count >= threshold) begin
            squeeze_store();
            res.compacted = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (cmd.slot_index >= fill_level) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = slot_value[cmd.slot_index];
          res.read_live  = slot_alive[cmd.slot_index];
        end
      end
      KIND_COMPACT: begin
        squeeze_store();
        res.compacted = 1'b1;
      end
      KIND_CLEAR: begin
        fill_level = '0;
        tomb_count = '0;
      end
      default: begin
      end
    endcase
    res.stored_count  = fill_level;
    res.pending_count = tomb_count;
  endtask

  always @(posedge clk) begin : watch
    tvc_out_t want;
    tvc_out_t got;
    if (rst) begin
      fill_level = '0;
      tomb_count = '0;
      threshold  = THRESHOLD_RESET;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result beat with none expected");
        end else begin
          want = owed_q.pop_front();
          got  = out_data;
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("read_value", got.read_value, want.read_value);
          check_field("read_live", 32'(got.read_live), 32'(want.read_live));
          check_field("stored_count", 32'(got.stored_count), 32'(want.stored_count));
          check_field("pending_count", 32'(got.pending_count), 32'(want.pending_count));
          check_field("compacted", 32'(got.compacted), 32'(want.compacted));
        end
      end
      if (in_valid && in_ready) begin
        predict_beat(in_data, want);
        owed_q = {owed_q, want};
      end
      if (cfg_we) begin
        threshold = cfg_wdata;
      end
    end
    owed_n = owed_q.size();
  end

endmodule

FILE: dv/tombstone_vector_with_compaction_top_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives command beats and threshold writes into the tombstone store, gives the verdict.
module tombstone_vector_with_compaction_top_tb;
  import tvc_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  tvc_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tvc_out_t   out_data;
  logic       cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;

  int fail_count;
  int results_owed;
  int in_idle_pct  = 38;
  int out_idle_pct = 38;
  bit hold_req     = 1'b0;

  tombstone_vector_with_compaction_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tvc_store_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic tvc_in_t make_cmd(input logic [2:0] kind, input logic [5:0] idx,
                                       input logic [31:0] value);
    tvc_in_t cmd;
    cmd.kind       = kind;
    cmd.slot_index = idx;
    cmd.new_value  = value;
    return cmd;
  endfunction

  function automatic tvc_in_t random_cmd(input int append_pct, input int erase_pct,
                                         input int read_pct);
    int          r;
    int          s;
    logic [2:0]  kind;
    logic [5:0]  idx;
    r = $urandom_range(99);
    s = $urandom_range(9);
    if (r < append_pct) begin
      kind = KIND_APPEND;
    end else if (r < append_pct + erase_pct) begin
      kind = KIND_ERASE;
    end else if (r < append_pct + erase_pct + read_pct) begin
      kind = KIND_READ;
    end else if (s < 5) begin
      kind = KIND_COMPACT;
    end else if (s < 7) begin
      kind = KIND_CLEAR;
    end else begin
      kind = KIND_CLEAR + 3'($urandom_range(1, 3));
    end
    if ($urandom_range(1)) begin
      idx = 6'($urandom_range(15));
    end else begin
      idx = 6'($urandom_range(CAPACITY - 1));
    end
    return make_cmd(kind, idx, $urandom);
  endfunction

  // entered and left at a falling edge; valid stays up for a following beat
  task automatic send_beat(input tvc_in_t cmd);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [6:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int beats, input int append_pct, input int erase_pct,
                           input int read_pct);
    repeat (beats) send_beat(random_cmd(append_pct, erase_pct, read_pct));
    settle();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(make_cmd(KIND_READ, '0, '0));
    send_beat(make_cmd(KIND_ERASE, '0, '0));
    send_beat(make_cmd(KIND_COMPACT, '0, '0));
    send_beat(make_cmd(KIND_APPEND, '1, '0));
    send_beat(make_cmd(KIND_APPEND, '0, '1));
    send_beat(make_cmd(KIND_APPEND, '0, 32'haaaa_aaaa));
    send_beat(make_cmd(KIND_APPEND, '0, 32'h5555_5555));
    send_beat(make_cmd(KIND_READ, '0, '1));
    send_beat(make_cmd(KIND_READ, 6'd1, '0));
    send_beat(make_cmd(KIND_ERASE, 6'd1, '0));
    send_beat(make_cmd(KIND_ERASE, 6'd1, '0));
    send_beat(make_cmd(KIND_READ, 6'd1, '0));
    send_beat(make_cmd(KIND_READ, '1, '0));
    send_beat(make_cmd(KIND_ERASE, '1, '0));
    send_beat(make_cmd(KIND_CLEAR + 3'd1, '1, '1));
    send_beat(make_cmd(KIND_CLEAR + 3'd2, '0, '0));
    send_beat(make_cmd(KIND_CLEAR + 3'd3, '1, '1));
    send_beat(make_cmd(KIND_COMPACT, '0, '0));
    send_beat(make_cmd(KIND_READ, 6'd1, '0));
    send_beat(make_cmd(KIND_CLEAR, '0, '0));
    send_beat(make_cmd(KIND_READ, '0, '0));
    send_beat(make_cmd(KIND_APPEND, '0, 32'h1234_5678));
    settle();

    run_phase(300, 45, 30, 20);
    run_phase(150, 90, 5, 5);
    run_phase(150, 20, 60, 20);

    write_threshold('0);
    hold_req = 1'b1;
    run_phase(250, 45, 30, 20);

    write_threshold(7'd1);
    run_phase(200, 50, 25, 20);

    write_threshold(7'(CAPACITY));
    run_phase(120, 90, 5, 5);
    run_phase(200, 10, 80, 10);

    write_threshold('1);
    run_phase(200, 45, 30, 20);

    write_threshold(THRESHOLD_RESET);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_phase(150, 45, 30, 20);

    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
